// ===== hdl/gha_pkg.sv =====
// ============================================================================
// gha_pkg
// Shared types and codes for the generational handle allocator.
// ============================================================================
package gha_pkg;

    localparam int GEN_W     = 24;
    localparam int KIND_W    = 8;
    localparam int OWNER_W   = 64;
    localparam int HANDLE_W  = 64;
    localparam int FIELD_W   = 32;
    localparam int Q_DEPTH   = 2;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_ALLOC   = 2'd0;
    localparam t_cmd CMD_RELEASE = 2'd1;
    localparam t_cmd CMD_RESOLVE = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status ST_DONE   = 2'd0;
    localparam t_status ST_REJECT = 2'd1;
    localparam t_status ST_FULL   = 2'd2;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_RELEASE,
        OP_RESOLVE,
        OP_REJECT
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [FIELD_W-1:0]  idx;
        logic [GEN_W-1:0]    gen;
        logic [KIND_W-1:0]   kind;
        logic [OWNER_W-1:0]  owner;
    } t_cmd_word;

    typedef struct packed {
        logic [OWNER_W-1:0]  owner;
        logic [GEN_W-1:0]    gen;
        logic [KIND_W-1:0]   kind;
        logic                busy;
    } t_slot_word;

    typedef enum logic {
        BK_IDLE,
        BK_EXEC
    } t_back_state;

endpackage

// ===== hdl/gha_ram.sv =====
// ============================================================================
// gha_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== hdl/gha_front.sv =====
// ============================================================================
// gha_front
// Command intake: classifies each word and queues it for the back end.
// ============================================================================
module gha_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [7:0]             i_reserved_kind,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  gha_pkg::t_cmd          i_cmd,
    input  logic [63:0]            i_handle_in,
    input  logic [7:0]             i_kind,
    input  logic [63:0]            i_owner_in,
    output logic                   o_q_valid,
    output gha_pkg::t_cmd_word     o_q_word,
    input  logic                   i_q_pop
);
    import gha_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_cmd_word            r_q [Q_DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr;
    logic [PTR_W-1:0]     r_rd_ptr;
    logic [CNT_W-1:0]     r_count;
    t_cmd_word            in_word;
    logic                 handle_ok;
    logic                 push;

    always_comb begin
        handle_ok      = (i_handle_in[FIELD_W-1:0] != '0) &&
                         (i_handle_in[63:56] == i_kind);
        in_word.idx    = i_handle_in[FIELD_W-1:0];
        in_word.gen    = i_handle_in[55:32];
        in_word.kind   = i_kind;
        in_word.owner  = i_owner_in;
        unique case (i_cmd)
            CMD_ALLOC: begin
                in_word.op = (i_owner_in != '0 && i_kind != i_reserved_kind)
                             ? OP_ALLOC : OP_REJECT;
            end
            CMD_RELEASE: begin
                in_word.op = handle_ok ? OP_RELEASE : OP_REJECT;
            end
            CMD_RESOLVE: begin
                in_word.op = handle_ok ? OP_RESOLVE : OP_REJECT;
            end
            default: begin
                in_word.op = OP_REJECT;
            end
        endcase
    end

    assign o_in_stall = (r_count == CNT_W'(Q_DEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != '0);
    assign o_q_word   = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_q_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            case ({push, i_q_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hdl/gha_back.sv =====
// ============================================================================
// gha_back
// Command execution: slot table and free stack access, result register.
// ============================================================================
module gha_back #(
    parameter int SLOT_COUNT = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [7:0]             i_reserved_kind,
    input  logic                   i_q_valid,
    input  gha_pkg::t_cmd_word     i_q_word,
    output logic                   o_q_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output gha_pkg::t_status       o_status,
    output logic [63:0]            o_handle_out,
    output logic [63:0]            o_owner_out
);
    import gha_pkg::*;

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam int STK_W = IDX_W + GEN_W;
    localparam int SLT_W = $bits(t_slot_word);

    t_back_state         r_state, n_state;
    t_cmd_word           r_work;
    logic [CNT_W-1:0]    r_free_count, n_free_count;
    logic [CNT_W-1:0]    r_mark, n_mark;
    logic                r_out_valid, n_out_valid;
    t_status             r_status, n_status;
    logic [63:0]         r_handle, n_handle;
    logic [63:0]         r_owner, n_owner;

    logic                slot_re, slot_we, stk_re, stk_we;
    logic [IDX_W-1:0]    slot_raddr, slot_waddr, stk_raddr, stk_waddr;
    t_slot_word          slot_wdata, slot_rdata;
    logic [SLT_W-1:0]    slot_rbits;
    logic [STK_W-1:0]    stk_wdata, stk_rdata;
    logic [FIELD_W-1:0]  q_idx_m1, work_idx_m1;
    logic [IDX_W-1:0]    work_slot;
    logic [IDX_W-1:0]    alloc_slot;
    logic [GEN_W-1:0]    alloc_gen, gen_inc, gen_next;
    logic                handle_ok, out_free, exec_go;

    gha_ram #(.WIDTH(SLT_W), .DEPTH(SLOT_COUNT)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_re    (slot_re),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rbits)
    );

    gha_ram #(.WIDTH(STK_W), .DEPTH(SLOT_COUNT)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign slot_rdata  = t_slot_word'(slot_rbits);
    assign q_idx_m1    = i_q_word.idx - FIELD_W'(1);
    assign work_idx_m1 = r_work.idx - FIELD_W'(1);
    assign work_slot   = work_idx_m1[IDX_W-1:0];
    assign out_free    = !r_out_valid || !i_out_stall;
    assign exec_go     = (r_state == BK_EXEC) && out_free;

    // Index is known nonzero; slots at or above the mark were never handed out.
    assign handle_ok = (r_work.idx <= FIELD_W'(r_mark)) && slot_rdata.busy &&
                       (slot_rdata.kind == r_work.kind) &&
                       (slot_rdata.gen == r_work.gen);
    assign gen_inc   = slot_rdata.gen + GEN_W'(1);
    assign gen_next  = (gen_inc == '0) ? GEN_W'(1) : gen_inc;

    always_comb begin
        unique case (r_state)
            BK_IDLE: n_state = i_q_valid ? BK_EXEC : BK_IDLE;
            BK_EXEC: n_state = out_free ? BK_IDLE : BK_EXEC;
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop      = 1'b0;
        slot_re      = 1'b0;
        slot_raddr   = q_idx_m1[IDX_W-1:0];
        stk_re       = 1'b0;
        stk_raddr    = IDX_W'(r_free_count - CNT_W'(1));
        slot_we      = 1'b0;
        slot_waddr   = work_slot;
        slot_wdata   = '0;
        stk_we       = 1'b0;
        stk_waddr    = r_free_count[IDX_W-1:0];
        stk_wdata    = {work_slot, gen_next};
        n_free_count = r_free_count;
        n_mark       = r_mark;
        n_out_valid  = r_out_valid && i_out_stall;
        n_status     = r_status;
        n_handle     = r_handle;
        n_owner      = r_owner;
        alloc_slot   = r_mark[IDX_W-1:0];
        alloc_gen    = GEN_W'(1);
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    slot_re = 1'b1;
                    stk_re  = 1'b1;
                end
            end
            BK_EXEC: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_REJECT;
                    n_handle    = '0;
                    n_owner     = '0;
                    case (r_work.op)
                        OP_ALLOC: begin
                            if (r_free_count != '0) begin
                                // pop the most recently freed slot
                                alloc_slot   = stk_rdata[STK_W-1 -: IDX_W];
                                alloc_gen    = stk_rdata[GEN_W-1:0];
                                n_free_count = r_free_count - CNT_W'(1);
                            end else if (r_mark < CNT_W'(SLOT_COUNT)) begin
                                n_mark = r_mark + CNT_W'(1);
                            end
                            if (r_free_count != '0 || r_mark < CNT_W'(SLOT_COUNT)) begin
                                slot_we          = 1'b1;
                                slot_waddr       = alloc_slot;
                                slot_wdata.owner = r_work.owner;
                                slot_wdata.gen   = alloc_gen;
                                slot_wdata.kind  = r_work.kind;
                                slot_wdata.busy  = 1'b1;
                                n_status = ST_DONE;
                                n_handle = {r_work.kind, alloc_gen,
                                            FIELD_W'(alloc_slot) + FIELD_W'(1)};
                            end else begin
                                n_status = ST_FULL;
                            end
                        end
                        OP_RELEASE: begin
                            if (handle_ok && r_free_count < CNT_W'(SLOT_COUNT)) begin
                                slot_we          = 1'b1;
                                slot_wdata.owner = '0;
                                slot_wdata.gen   = gen_next;
                                slot_wdata.kind  = i_reserved_kind;
                                slot_wdata.busy  = 1'b0;
                                stk_we           = 1'b1;
                                n_free_count     = r_free_count + CNT_W'(1);
                                n_status         = ST_DONE;
                            end
                        end
                        OP_RESOLVE: begin
                            if (handle_ok) begin
                                n_status = ST_DONE;
                                n_owner  = slot_rdata.owner;
                            end
                        end
                        default: begin
                            n_status = ST_REJECT;
                        end
                    endcase
                end
            end
            default: begin
                n_out_valid = r_out_valid && i_out_stall;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_work <= i_q_word;
        end
        if (exec_go) begin
            r_status <= n_status;
            r_handle <= n_handle;
            r_owner  <= n_owner;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_IDLE;
            r_free_count <= '0;
            r_mark       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_free_count <= n_free_count;
            r_mark       <= n_mark;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_handle_out = r_handle;
    assign o_owner_out  = r_owner;

endmodule

// ===== hdl/generational_handle_allocator.sv =====
// ============================================================================
// generational_handle_allocator
// Slot table handing out 64-bit generational handles: allocate, release,
// resolve.
// ============================================================================
// Command words enter on i_in_valid / o_in_stall with i_cmd, i_handle_in,
// i_kind and i_owner_in. One result word per command leaves on o_out_valid /
// i_out_stall with o_status, o_handle_out and o_owner_out, in command order.
// The reserved kind register is written through i_cfg_valid / o_cfg_ready,
// which is always ready; write it only while no command is in flight.
// A two-word queue separates intake from execution. Each command passes
// the back-end states in order: BK_IDLE pops it and issues the slot table
// and free stack reads, BK_EXEC does the check, write-back and result load.
// The next command is popped only once the back end is back in BK_IDLE, so
// commands do not overlap in execution. A stalled result holds in the output
// register while the queue keeps taking words; intake stalls once the queue
// is full and execution waits on the occupied output register.
// Reset clears the queue, the free stack count, the high-water mark of used
// slots and the reserved kind; table contents need no clearing, since only
// slots below the mark and stack entries below the count are ever used.
// ============================================================================
module generational_handle_allocator #(
    parameter int SLOT_COUNT = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_cmd,
    input  logic [63:0]         i_handle_in,
    input  logic [7:0]          i_kind,
    input  logic [63:0]         i_owner_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_status,
    output logic [63:0]         o_handle_out,
    output logic [63:0]         o_owner_out
);
    import gha_pkg::*;

    logic [7:0]   r_reserved_kind;
    logic         q_valid;
    logic         q_pop;
    t_cmd_word    q_word;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reserved_kind <= '0;
        end else if (i_cfg_valid) begin
            r_reserved_kind <= i_cfg_data;
        end
    end

    gha_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_reserved_kind (r_reserved_kind),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_handle_in     (i_handle_in),
        .i_kind          (i_kind),
        .i_owner_in      (i_owner_in),
        .o_q_valid       (q_valid),
        .o_q_word        (q_word),
        .i_q_pop         (q_pop)
    );

    gha_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_reserved_kind (r_reserved_kind),
        .i_q_valid       (q_valid),
        .i_q_word        (q_word),
        .o_q_pop         (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_handle_out    (o_handle_out),
        .o_owner_out     (o_owner_out)
    );

endmodule
